[rtl/core/gps_pkg.sv]
`timescale 1ns / 1ps

package gps_pkg;

    localparam int STEP_WIDTH_DEF     = 16;
    localparam int PATHS_LOG2_MAX_DEF = 20;
    localparam int EXP_ITERATIONS_DEF = 24;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PRICE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLATILITY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_PATH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATHS_LOG2     = 3'd5;

    // ln2 in Q.40
    localparam logic [39:0] LN2_Q40  = 40'd762123384786;
    // bias keeps the log-return positive for the k search
    localparam int          K_BIAS   = 256;
    localparam int          K_BITS   = 9;
    localparam logic [50:0] X_OFFSET = 51'(LN2_Q40) * 51'(K_BIAS);

    typedef struct packed {
        logic [31:0]        initial_price;
        logic signed [31:0] drift_rate;
        logic [30:0]        volatility;
        logic [31:0]        horizon;
        logic [15:0]        steps_per_path;
        logic [4:0]         paths_log2;
    } cfg_t;

    typedef struct packed {
        logic [15:0] normal_sample;
        logic [31:0] init_price;
        logic        run_start;
        logic        path_start;
        logic [15:0] step_index;
        logic [19:0] path_index;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [31:0] price;
        logic [15:0] step_index;
        logic [19:0] path_index;
        logic        last_of_path;
    } out_t;

    typedef struct packed {
        logic start;
    } fac_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] drift;
        logic [31:0]        diff;
    } fac_res_t;

endpackage

[rtl/core/gps_front.sv]
`timescale 1ns / 1ps

module gps_front import gps_pkg::*; #(
    parameter int STEP_WIDTH     = STEP_WIDTH_DEF,
    parameter int PATHS_LOG2_MAX = PATHS_LOG2_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 cfg_ready,
    input  logic                 s_tvalid,
    input  logic [15:0]          s_tdata,
    output logic                 s_tready,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd,
    output cfg_t                 cfg,
    output logic [15:0]          steps_eff
);

    localparam int PW = (PATHS_LOG2_MAX < 1) ? 1 : PATHS_LOG2_MAX;
    localparam int CW = (STEP_WIDTH > 16) ? STEP_WIDTH : 16;
    localparam int PE = (PW > 20) ? PW : 20;
    localparam logic [15:0] STEP_CAP =
        (STEP_WIDTH >= 16) ? 16'hFFFF : 16'((1 << STEP_WIDTH) - 1);

    cfg_t                  cfg_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [PW-1:0]         path_reg;

    logic [15:0]           s16;
    logic [5:0]            lg_eff;
    logic [STEP_WIDTH-1:0] step_new;
    logic [CW-1:0]         step_ext;
    logic [CW-1:0]         steps_ext;
    logic [PE-1:0]         path_ext;
    logic [PW:0]           path_inc;
    logic [PW:0]           npaths;
    logic                  last;

    assign cfg       = cfg_reg;
    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    always_comb begin
        s16       = (cfg_reg.steps_per_path == 16'd0) ? 16'd1 : cfg_reg.steps_per_path;
        steps_eff = (s16 > STEP_CAP) ? STEP_CAP : s16;
        lg_eff    = ({1'b0, cfg_reg.paths_log2} > 6'(PATHS_LOG2_MAX)) ?
                    6'(PATHS_LOG2_MAX) : {1'b0, cfg_reg.paths_log2};
        step_new  = step_reg + 1'b1;
        step_ext  = CW'(step_new);
        steps_ext = CW'(steps_eff);
        last      = (step_ext >= steps_ext) || (step_new == '0);
        path_ext  = PE'(path_reg);
        path_inc  = {1'b0, path_reg} + 1'b1;
        npaths    = (PW+1)'(1) << lg_eff;

        q_cmd.normal_sample = s_tdata;
        q_cmd.init_price    = cfg_reg.initial_price;
        q_cmd.run_start     = (step_reg == '0) && (path_reg == '0);
        q_cmd.path_start    = (step_reg == '0);
        q_cmd.step_index    = step_ext[15:0];
        q_cmd.path_index    = path_ext[19:0];
        q_cmd.last          = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_price  <= 32'd65536;
            cfg_reg.drift_rate     <= '0;
            cfg_reg.volatility     <= '0;
            cfg_reg.horizon        <= 32'd65536;
            cfg_reg.steps_per_path <= 16'd1;
            cfg_reg.paths_log2     <= '0;
            step_reg               <= '0;
            path_reg               <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_INITIAL_PRICE:  cfg_reg.initial_price  <= cfg_data;
                    REG_DRIFT_RATE:     cfg_reg.drift_rate     <= cfg_data;
                    REG_VOLATILITY:     cfg_reg.volatility     <= cfg_data[30:0];
                    REG_HORIZON:        cfg_reg.horizon        <= cfg_data;
                    REG_STEPS_PER_PATH: cfg_reg.steps_per_path <= cfg_data[15:0];
                    REG_PATHS_LOG2:     cfg_reg.paths_log2     <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (q_push) begin
                if (last) begin
                    step_reg <= '0;
                    path_reg <= (path_inc >= npaths) ? '0 : path_inc[PW-1:0];
                end else begin
                    step_reg <= step_new;
                end
            end
        end
    end

endmodule

[rtl/core/gps_queue.sv]
`timescale 1ns / 1ps

module gps_queue import gps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t cmd_out,
    output logic full,
    output logic empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= cmd_in;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/core/gps_factors.sv]
`timescale 1ns / 1ps

module gps_factors import gps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic [15:0] steps_eff,
    input  fac_req_t    req,
    output fac_res_t    res
);

    typedef enum logic [9:0] {
        F_IDLE  = 10'b0000000001,
        F_DIV   = 10'b0000000010,
        F_SQ    = 10'b0000000100,
        F_A     = 10'b0000001000,
        F_MUL   = 10'b0000010000,
        F_DRIFT = 10'b0000100000,
        F_NORM  = 10'b0001000000,
        F_SQRT  = 10'b0010000000,
        F_DPROD = 10'b0100000000,
        F_DIFF  = 10'b1000000000
    } fstate_t;

    fstate_t            state_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        dvd_reg;
    logic [15:0]        rem_reg;
    logic [61:0]        sq_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        pp_reg;
    logic [1:0]         pp_sh_reg;
    logic [127:0]       acc_reg;
    logic [63:0]        dn_reg;
    logic [4:0]         k_reg;
    logic [63:0]        n_reg;
    logic [63:0]        root_reg;
    logic [62:0]        dprod_reg;
    logic               done_reg;
    logic signed [31:0] drift_reg;
    logic [31:0]        diff_reg;

    logic [16:0]        rem_sh;
    logic               qbit;
    logic signed [62:0] a_val;
    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [32:0]        dres;
    logic [63:0]        sbit;
    logic [63:0]        strial;
    logic [5:0]         shamt;
    logic [62:0]        dsh;

    assign res.done  = done_reg;
    assign res.drift = drift_reg;
    assign res.diff  = diff_reg;

    always_comb begin
        rem_sh = {rem_reg, dvd_reg[63]};
        qbit   = (rem_sh >= {1'b0, steps_eff});
        a_val  = $signed({{3{cfg.drift_rate[31]}}, cfg.drift_rate, 28'b0})
               - $signed({2'b0, sq_reg[61:1]});
        a_half = cnt_reg[1] ? mag_reg[63:32] : mag_reg[31:0];
        b_half = cnt_reg[0] ? dvd_reg[63:32] : dvd_reg[31:0];
        if (|acc_reg[127:91]) begin
            dres = 33'h1_0000_0000;
        end else begin
            dres = {2'b0, acc_reg[90:64], acc_reg[63:60]};
        end
        sbit   = 64'd1 << {cnt_reg[4:0], 1'b0};
        strial = root_reg + sbit;
        shamt  = 6'd16 + {1'b0, k_reg};
        dsh    = dprod_reg >> shamt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            drift_reg <= '0;
            diff_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                F_IDLE: begin
                    if (req.start) begin
                        dvd_reg   <= {cfg.horizon, 32'b0};
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    rem_reg <= qbit ? 16'(rem_sh - {1'b0, steps_eff}) : rem_sh[15:0];
                    dvd_reg <= {dvd_reg[62:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'd63) begin
                        state_reg <= F_SQ;
                    end
                end
                F_SQ: begin
                    sq_reg    <= 62'(cfg.volatility * cfg.volatility);
                    state_reg <= F_A;
                end
                F_A: begin
                    neg_reg   <= a_val[62];
                    mag_reg   <= {1'b0, a_val[62] ? 63'(-a_val) : 63'(a_val)};
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= F_MUL;
                end
                F_MUL: begin
                    if (cnt_reg[2:0] != 3'd4) begin
                        pp_reg    <= 64'(a_half * b_half);
                        pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    end
                    if (cnt_reg[2:0] != 3'd0) begin
                        acc_reg <= acc_reg + ({64'b0, pp_reg} << {pp_sh_reg, 5'b0});
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[2:0] == 3'd4) begin
                        state_reg <= F_DRIFT;
                    end
                end
                F_DRIFT: begin
                    if (neg_reg) begin
                        drift_reg <= (dres > 33'h0_8000_0000) ? 32'sh8000_0000 :
                                     $signed(32'(~dres + 33'd1));
                    end else begin
                        drift_reg <= (dres > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                     $signed(dres[31:0]);
                    end
                    dn_reg    <= dvd_reg;
                    k_reg     <= '0;
                    state_reg <= F_NORM;
                end
                F_NORM: begin
                    if ((k_reg != 5'd31) && (dn_reg[63:62] == 2'b00)) begin
                        dn_reg <= dn_reg << 2;
                        k_reg  <= k_reg + 1'b1;
                    end else begin
                        n_reg     <= dn_reg;
                        root_reg  <= '0;
                        cnt_reg   <= 7'd31;
                        state_reg <= F_SQRT;
                    end
                end
                F_SQRT: begin
                    if (n_reg >= strial) begin
                        n_reg    <= n_reg - strial;
                        root_reg <= (root_reg >> 1) + sbit;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg[4:0] == 5'd0) begin
                        state_reg <= F_DPROD;
                    end
                end
                F_DPROD: begin
                    dprod_reg <= 63'(cfg.volatility * root_reg[31:0]);
                    state_reg <= F_DIFF;
                end
                F_DIFF: begin
                    diff_reg  <= (|dsh[62:32]) ? 32'hFFFF_FFFF : dsh[31:0];
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/gps_back.sv]
`timescale 1ns / 1ps

module gps_back import gps_pkg::*; #(
    parameter int EXP_ITERATIONS = EXP_ITERATIONS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_empty,
    input  cmd_t     q_cmd,
    output logic     q_pop,
    output fac_req_t fac_req,
    input  fac_res_t fac_res,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_item
);

    localparam int NW = $clog2(EXP_ITERATIONS + 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_FACT = 11'b00000000010,
        ST_INIT = 11'b00000000100,
        ST_XMUL = 11'b00000001000,
        ST_XSUM = 11'b00000010000,
        ST_KDIV = 11'b00000100000,
        ST_EMUL = 11'b00001000000,
        ST_EREC = 11'b00010000000,
        ST_ECOR = 11'b00100000000,
        ST_PMUL = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } bstate_t;

    logic [31:0] recip_tab [0:EXP_ITERATIONS];

    for (genvar g = 0; g <= EXP_ITERATIONS; g++) begin : g_recip
        localparam logic [33:0] RV = 34'h2_0000_0000 / ((g < 3) ? 1 : g);
        assign recip_tab[g] = (g < 3) ? 32'd0 : RV[31:0];
    end

    bstate_t            state_reg;
    cmd_t               cmd_reg;
    logic [31:0]        s_reg;
    logic signed [48:0] dz_reg;
    logic [49:0]        rem_reg;
    logic [K_BITS-1:0]  q_reg;
    logic [3:0]         i_reg;
    logic signed [10:0] k_reg;
    logic [31:0]        rr_reg;
    logic [32:0]        term_reg;
    logic [33:0]        sum_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        pr_reg;
    logic [31:0]        p_reg;
    logic [NW-1:0]      n_reg;
    logic [65:0]        pp_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic               out_free;
    logic               out_load;
    logic signed [50:0] xs;
    logic [49:0]        cand;
    logic [30:0]        q0;
    logic [37:0]        chk;
    logic [31:0]        qv;
    logic signed [10:0] sh;
    logic [10:0]        ls;
    logic [65:0]        pv;
    logic [31:0]        price;

    assign out_free    = !out_valid_reg || m_ready;
    assign out_load    = ((state_reg == ST_INIT) || (state_reg == ST_OUT)) && out_free;
    assign m_valid     = out_valid_reg;
    assign m_item      = out_reg;
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;
    assign fac_req.start = q_pop && q_cmd.run_start;

    always_comb begin
        xs   = $signed({{7{fac_res.drift[31]}}, fac_res.drift, 12'b0})
             + $signed({{2{dz_reg[48]}}, dz_reg}) + $signed(X_OFFSET);
        cand = 50'(LN2_Q40) << i_reg;
        q0   = pr_reg[63:33];
        chk  = 38'(p_reg) - 38'(q0) * 38'(n_reg);
        if (n_reg == NW'(1)) begin
            qv = p_reg;
        end else if (n_reg == NW'(2)) begin
            qv = p_reg >> 1;
        end else begin
            qv = (chk >= 38'(n_reg)) ? 32'(q0) + 32'd1 : 32'(q0);
        end

        sh    = 11'sd32 - k_reg;
        ls    = 11'(-sh);
        pv    = '0;
        price = '0;
        if (pp_reg == '0) begin
            price = '0;
        end else if (sh >= 11'sd66) begin
            price = '0;
        end else if (sh > 11'sd0) begin
            pv    = pp_reg >> sh[6:0];
            price = (|pv[65:32]) ? 32'hFFFF_FFFF : pv[31:0];
        end else if (ls >= 11'd32) begin
            price = 32'hFFFF_FFFF;
        end else if (pp_reg > (66'h0_FFFF_FFFF >> ls[4:0])) begin
            price = 32'hFFFF_FFFF;
        end else begin
            pv    = pp_reg << ls[4:0];
            price = pv[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg <= q_cmd;
                        if (q_cmd.path_start) begin
                            s_reg <= q_cmd.init_price;
                        end
                        if (q_cmd.run_start) begin
                            state_reg <= ST_FACT;
                        end else if (q_cmd.path_start) begin
                            state_reg <= ST_INIT;
                        end else begin
                            state_reg <= ST_XMUL;
                        end
                    end
                end
                ST_FACT: begin
                    if (fac_res.done) begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    if (out_free) begin
                        out_reg.price        <= s_reg;
                        out_reg.step_index   <= '0;
                        out_reg.path_index   <= cmd_reg.path_index;
                        out_reg.last_of_path <= 1'b0;
                        state_reg            <= ST_XMUL;
                    end
                end
                ST_XMUL: begin
                    dz_reg    <= $signed({1'b0, fac_res.diff}) *
                                 $signed(cmd_reg.normal_sample);
                    state_reg <= ST_XSUM;
                end
                ST_XSUM: begin
                    rem_reg   <= xs[49:0];
                    q_reg     <= '0;
                    i_reg     <= 4'(K_BITS - 1);
                    state_reg <= ST_KDIV;
                end
                ST_KDIV: begin
                    if (rem_reg >= cand) begin
                        rem_reg      <= rem_reg - cand;
                        q_reg[i_reg] <= 1'b1;
                    end
                    i_reg <= i_reg - 1'b1;
                    if (i_reg == 4'd0) begin
                        state_reg <= ST_EMUL;
                    end
                end
                ST_EMUL: begin
                    state_reg <= ST_EREC;
                    prod_reg  <= 64'(term_reg * rr_reg);
                end
                ST_EREC: begin
                    pr_reg    <= 64'(prod_reg[63:32] * recip_tab[n_reg]);
                    p_reg     <= prod_reg[63:32];
                    state_reg <= ST_ECOR;
                end
                ST_ECOR: begin
                    term_reg <= {1'b0, qv};
                    sum_reg  <= sum_reg + 34'(qv);
                    n_reg    <= n_reg + 1'b1;
                    if (n_reg == NW'(EXP_ITERATIONS)) begin
                        state_reg <= ST_PMUL;
                    end else begin
                        state_reg <= ST_EMUL;
                    end
                end
                ST_PMUL: begin
                    pp_reg    <= 66'(s_reg * sum_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_reg.price        <= price;
                        out_reg.step_index   <= cmd_reg.step_index;
                        out_reg.path_index   <= cmd_reg.path_index;
                        out_reg.last_of_path <= cmd_reg.last;
                        s_reg                <= price;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_KDIV && i_reg == 4'd0) begin
                k_reg    <= $signed({2'b0, q_reg[K_BITS-1:1],
                                     (rem_reg >= cand) | q_reg[0]}) - 11'sd256;
                rr_reg   <= (rem_reg >= cand) ? 32'((rem_reg - cand) >> 8) :
                                                32'(rem_reg >> 8);
                term_reg <= 33'h1_0000_0000;
                sum_reg  <= 34'h1_0000_0000;
                n_reg    <= NW'(1);
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result changed while stalled");

    a_fac_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fac_res.done |-> (state_reg == ST_FACT))
        else $error("factor unit finished outside the wait state");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty && (state_reg == ST_IDLE))
        else $error("queue popped while busy or empty");

endmodule

[rtl/core/gbm_path_stepper_top.sv]
`timescale 1ns / 1ps

// Geometric Brownian motion path stepper.
// s_ channel: one transfer per standard-normal sample (Q4.12 in s_tdata).
// m_ channel: one transfer per price; the first sample of each path yields
//   two transfers (initial price at step 0, then step 1). m_tlast marks the
//   final step of a path. After 2^paths_log2 paths the run starts over.
// cfg channel: register index and data, always ready; write only while idle.
// Per sample the back end's time is set mostly by the series loop for exp,
//   which takes each of the EXP_ITERATIONS terms through ST_EMUL, ST_EREC
//   and ST_ECOR, dividing by the term index through a reciprocal table.
// The first sample of each run also waits for the drift and diffusion
//   factors (divider, normalize, 32-step square root).
// A two-entry queue sits between the front end and the back end, so up to
//   two samples are taken ahead; s_tready drops when the queue is full.
// Results sit in an output register; a stalled m_tready holds the result and
//   the back end waits, the front end keeps filling the queue.
// Reset (aresetn low, synchronous) restores register defaults and restarts
//   at path 0, step 0.

module gbm_path_stepper_top import gps_pkg::*; #(
    parameter int STEP_WIDTH     = STEP_WIDTH_DEF,
    parameter int PATHS_LOG2_MAX = PATHS_LOG2_MAX_DEF,
    parameter int EXP_ITERATIONS = EXP_ITERATIONS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // normal_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // price, step_index, path_index, pad
    output logic                 m_tlast
);

    cfg_t        cfg;
    logic [15:0] steps_eff;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    fac_req_t    fac_req;
    fac_res_t    fac_res;
    out_t        m_item;

    gps_front #(
        .STEP_WIDTH     (STEP_WIDTH),
        .PATHS_LOG2_MAX (PATHS_LOG2_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg),
        .steps_eff (steps_eff)
    );

    gps_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (push_cmd),
        .pop     (q_pop),
        .cmd_out (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    gps_factors u_factors (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .steps_eff (steps_eff),
        .req       (fac_req),
        .res       (fac_res)
    );

    gps_back #(
        .EXP_ITERATIONS (EXP_ITERATIONS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .fac_req (fac_req),
        .fac_res (fac_res),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (m_item)
    );

    assign m_tdata = {4'b0, m_item.path_index, m_item.step_index, m_item.price};
    assign m_tlast = m_item.last_of_path;

endmodule
